// ===== hw/rtl/wscc_pkg.sv =====
// ----------------------------------------------------------------------------
// wscc_pkg
// Types and constants shared by the washer stepper cycle controller.
// ----------------------------------------------------------------------------
package wscc_pkg;

   // field widths
   localparam int StepsW  = 10;
   localparam int LimitW  = 4;
   localparam int DriveW  = 4;
   localparam int CsrIdxW = 2;

   // register reset values
   localparam logic [StepsW-1:0] NormalStepsReset   = 10'd512;
   localparam logic [StepsW-1:0] DelicateStepsReset = 10'd256;
   localparam logic [LimitW-1:0] NormalLimitReset   = 4'd15;
   localparam logic [LimitW-1:0] DelicateLimitReset = 4'd8;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrNormalSteps   = 2'd0;
   localparam logic [CsrIdxW-1:0] CsrDelicateSteps = 2'd1;
   localparam logic [CsrIdxW-1:0] CsrNormalLimit   = 2'd2;
   localparam logic [CsrIdxW-1:0] CsrDelicateLimit = 2'd3;

   // input item
   typedef struct packed {
      logic start_level;
      logic mode_level;
   } req_type;

   // result item
   typedef struct packed {
      logic [DriveW-1:0] coil_drive;
      logic              running;
      logic              delicate_selected;
      logic              wash_done;
   } rsp_type;

   // configuration registers
   typedef struct packed {
      logic [StepsW-1:0] normal_swing_steps;
      logic [StepsW-1:0] delicate_swing_steps;
      logic [LimitW-1:0] normal_swing_limit;
      logic [LimitW-1:0] delicate_swing_limit;
   } cfg_type;

   // controller state, coil position kept apart since its width follows the coil count
   typedef struct packed {
      logic              motor_on;
      logic              wash_mode;
      logic              start_half_pressed;
      logic              mode_half_pressed;
      logic              spin_direction;
      logic [LimitW-1:0] normal_swings_done;
      logic [LimitW-1:0] delicate_swings_done;
      logic [StepsW-1:0] step_in_swing;
      logic [DriveW-1:0] drive_latch;
   } state_type;

   localparam state_type StateReset = '{
      motor_on:             1'b0,
      wash_mode:            1'b0,
      start_half_pressed:   1'b0,
      mode_half_pressed:    1'b0,
      spin_direction:       1'b0,
      normal_swings_done:   '0,
      delicate_swings_done: '0,
      step_in_swing:        '0,
      drive_latch:          '0
   };

endpackage

// ===== hw/rtl/wscc_csr.sv =====
// ----------------------------------------------------------------------------
// wscc_csr
// Configuration register bank: swing lengths and swing limits per mode.
// ----------------------------------------------------------------------------
module wscc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wscc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [wscc_pkg::StepsW-1:0]     csr_data,
   output wscc_pkg::cfg_type               cfg
);
   import wscc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CsrNormalSteps:   cfg_in.normal_swing_steps   = csr_data;
            CsrDelicateSteps: cfg_in.delicate_swing_steps = csr_data;
            CsrNormalLimit:   cfg_in.normal_swing_limit   = csr_data[LimitW-1:0];
            CsrDelicateLimit: cfg_in.delicate_swing_limit = csr_data[LimitW-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.normal_swing_steps   <= NormalStepsReset;
         cfg_ff.delicate_swing_steps <= DelicateStepsReset;
         cfg_ff.normal_swing_limit   <= NormalLimitReset;
         cfg_ff.delicate_swing_limit <= DelicateLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/wscc_step.sv =====
// ----------------------------------------------------------------------------
// wscc_step
// One tick of the wash program: button sampling, swing stepping, finish.
// ----------------------------------------------------------------------------
module wscc_step #(
   parameter int COIL_COUNT = 4
) (
   input  wscc_pkg::req_type                        req,
   input  wscc_pkg::cfg_type                        cfg,
   input  wscc_pkg::state_type                      state,
   input  logic [$clog2(COIL_COUNT)-1:0]            coil_position,
   output wscc_pkg::state_type                      state_next,
   output logic [$clog2(COIL_COUNT)-1:0]            coil_position_next,
   output wscc_pkg::rsp_type                        rsp
);
   import wscc_pkg::*;

   localparam int CoilW = $clog2(COIL_COUNT);
   localparam logic [CoilW-1:0] LastCoil = CoilW'(COIL_COUNT - 1);

   logic              do_step;
   logic              done;
   logic [LimitW-1:0] count;
   logic [LimitW-1:0] limit;
   logic [StepsW-1:0] len;
   logic [StepsW-1:0] step_inc;
   logic [7:0]        onehot;

   assign count    = state.wash_mode ? state.delicate_swings_done : state.normal_swings_done;
   assign limit    = state.wash_mode ? cfg.delicate_swing_limit : cfg.normal_swing_limit;
   assign len      = state.wash_mode ? cfg.delicate_swing_steps : cfg.normal_swing_steps;
   assign step_inc = state.step_in_swing + StepsW'(1);
   assign onehot   = 8'(8'd1 << coil_position);

   always_comb begin
      state_next         = state;
      coil_position_next = coil_position;
      do_step            = 1'b0;
      done               = 1'b0;

      // sampling: mid-swing nothing, running start only, stopped mode then start
      if (state.step_in_swing != '0) begin
         do_step = 1'b1;
      end else if (state.motor_on) begin
         if (req.start_level) begin
            if (state.start_half_pressed) begin
               state_next.start_half_pressed = 1'b0;
               state_next.motor_on           = 1'b0;
            end else begin
               state_next.start_half_pressed = 1'b1;
            end
         end
         if (count < limit) begin
            do_step = 1'b1;
         end else begin
            // wash finished: counters and coils clear, mode and press flags kept
            state_next.motor_on             = 1'b0;
            state_next.spin_direction       = 1'b0;
            state_next.normal_swings_done   = '0;
            state_next.delicate_swings_done = '0;
            state_next.drive_latch          = '0;
            coil_position_next              = '0;
            done                            = 1'b1;
         end
      end else begin
         if (req.mode_level) begin
            if (state.mode_half_pressed) begin
               state_next.mode_half_pressed = 1'b0;
               state_next.wash_mode         = ~state.wash_mode;
            end else begin
               state_next.mode_half_pressed = 1'b1;
            end
         end
         if (req.start_level) begin
            if (state.start_half_pressed) begin
               state_next.start_half_pressed = 1'b0;
               state_next.motor_on           = 1'b1;
            end else begin
               state_next.start_half_pressed = 1'b1;
            end
         end
      end

      // one coil step, swing ends when the count reaches the length or wraps
      if (do_step) begin
         state_next.drive_latch = onehot[DriveW-1:0];
         if (!state.spin_direction) begin
            coil_position_next = (coil_position == LastCoil) ? '0 : coil_position + CoilW'(1);
         end else begin
            coil_position_next = (coil_position == '0) ? LastCoil : coil_position - CoilW'(1);
         end
         state_next.step_in_swing = step_inc;
         if (step_inc >= len || step_inc == '0) begin
            state_next.step_in_swing  = '0;
            state_next.spin_direction = ~state.spin_direction;
            if (state.wash_mode) begin
               state_next.delicate_swings_done = state.delicate_swings_done + LimitW'(1);
            end else begin
               state_next.normal_swings_done = state.normal_swings_done + LimitW'(1);
            end
         end
      end
   end

   // result of this tick
   assign rsp.coil_drive        = state_next.drive_latch;
   assign rsp.running           = state_next.motor_on;
   assign rsp.delicate_selected = state_next.wash_mode;
   assign rsp.wash_done         = done;

endmodule

// ===== hw/rtl/washer_stepper_cycle_controller_top.sv =====
// ----------------------------------------------------------------------------
// washer_stepper_cycle_controller_top
// Washer stepper motor program: swing stepping, direction reversal, wash end.
// ----------------------------------------------------------------------------
// Each accepted item is one motor-step tick and yields exactly one result, held
// in the result register. The tick update is a single pass of small counter and flag logic
// from the state registers into the result register, so one item is taken
// every cycle; req_stall rises only while a held result is stalled by rsp_stall.
// Configuration writes are taken at any cycle (csr_ready is tied high) and are
// meant to be done while no item is in flight.
// ----------------------------------------------------------------------------
module washer_stepper_cycle_controller_top #(
   parameter int COIL_COUNT = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   // input channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  wscc_pkg::req_type               req_data,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output wscc_pkg::rsp_type               rsp_data,
   // configuration write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [wscc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [wscc_pkg::StepsW-1:0]     csr_data
);
   import wscc_pkg::*;

   localparam int CoilW = $clog2(COIL_COUNT);

   cfg_type          cfg;
   state_type        state_ff;
   state_type        state_in;
   logic [CoilW-1:0] coil_ff;
   logic [CoilW-1:0] coil_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;
   logic             rsp_valid_ff;
   logic             accept;

   wscc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   wscc_step #(
      .COIL_COUNT (COIL_COUNT)
   ) u_step (
      .req                (req_data),
      .cfg                (cfg),
      .state              (state_ff),
      .coil_position      (coil_ff),
      .state_next         (state_in),
      .coil_position_next (coil_in),
      .rsp                (rsp_in)
   );

   // take an item unless the result register is held
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // state registers advance once per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StateReset;
         coil_ff  <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         coil_ff  <= coil_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
